FILE: sv/tssfw_pkg.sv
// ----------------------------------------------------------------------------
// tssfw_pkg
// Types, codes and segment tables shared by the display frame writer.
// ----------------------------------------------------------------------------
package tssfw_pkg;

	localparam int DIGIT_COUNT = 4;
	localparam int SLOT_COUNT  = 8;

	localparam logic [1:0] OP_SHOW  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	localparam logic [1:0] CFG_DATA_CMD  = 2'd0;
	localparam logic [1:0] CFG_ADDR_CMD  = 2'd1;
	localparam logic [1:0] CFG_MINUS_PAT = 2'd2;

	localparam logic [7:0] COLON_BIT = 8'h80;

	localparam logic [2:0] SLOT_SINGLE = 3'd0;
	localparam logic [2:0] SLOT_CLR3   = 3'd1;
	localparam logic [2:0] SLOT_CLR2   = 3'd2;
	localparam logic [2:0] SLOT_CLR1   = 3'd3;
	localparam logic [2:0] SLOT_CLR0   = 3'd4;
	localparam logic [2:0] SLOT_TENTHS = 3'd5;
	localparam logic [2:0] SLOT_UNITS  = 3'd6;
	localparam logic [2:0] SLOT_TENS   = 3'd7;

	localparam logic [1:0] PH_DATA = 2'd0;
	localparam logic [1:0] PH_ADDR = 2'd1;
	localparam logic [1:0] PH_SEG  = 2'd2;

	typedef enum logic [2:0] {
		FS_IDLE,
		FS_DIV1,
		FS_DIV2,
		FS_DIV3,
		FS_PUSH
	} front_state_t;

	typedef struct packed {
		logic [SLOT_COUNT-1:0] slot_mask;
		logic                  use_minus;
		logic [1:0]            pos;
		logic [7:0]            seg;
		logic                  colon;
		logic [3:0]            d_tenths;
		logic [3:0]            d_units;
		logic [3:0]            d_tens;
	} queue_entry_t;

	typedef struct packed {
		logic [7:0] data_cmd;
		logic [7:0] addr_cmd;
		logic [7:0] minus_pat;
	} cfg_t;

	function automatic logic [7:0] digit_pattern(input logic [3:0] d);
		logic [7:0] p;
		case (d)
			4'd0:    p = 8'h3F;
			4'd1:    p = 8'h06;
			4'd2:    p = 8'h5B;
			4'd3:    p = 8'h4F;
			4'd4:    p = 8'h66;
			4'd5:    p = 8'h6D;
			4'd6:    p = 8'h7D;
			4'd7:    p = 8'h07;
			4'd8:    p = 8'h7F;
			4'd9:    p = 8'h6F;
			default: p = 8'h3F;
		endcase
		return p;
	endfunction

endpackage

FILE: sv/tssfw_if.sv
// ----------------------------------------------------------------------------
// tssfw_if
// Request, byte and configuration channels of the display frame writer.
// ----------------------------------------------------------------------------
interface tssfw_req_if;
	logic               valid;
	logic               ready;
	logic        [1:0]  operation;
	logic signed [16:0] temp_tenths;
	logic        [1:0]  position;
	logic        [7:0]  segments;
	logic               colon;

	modport source (output valid, operation, temp_tenths, position, segments, colon,
		input ready);
	modport sink (input valid, operation, temp_tenths, position, segments, colon,
		output ready);
endinterface

interface tssfw_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] bus_byte;
	logic       start_before;
	logic       stop_after;
	logic       last;

	modport source (output valid, bus_byte, start_before, stop_after, last, input ready);
	modport sink (input valid, bus_byte, start_before, stop_after, last, output ready);
endinterface

interface tssfw_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] index;
	logic [7:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: sv/tssfw_front.sv
// ----------------------------------------------------------------------------
// tssfw_front
// Accepts requests, splits the temperature into digits and queues a plan.
// ----------------------------------------------------------------------------
module tssfw_front (
	input  logic                   clk,
	input  logic                   arst_n,
	tssfw_req_if.sink              req,
	output logic                   push,
	output tssfw_pkg::queue_entry_t push_entry,
	input  logic                   full
);
	import tssfw_pkg::*;

	front_state_t state_q, state_d;
	logic         prev_neg_q;
	logic         accept;
	logic         raw_neg;
	logic [15:0]  raw_mag;
	logic [15:0]  mag_q;
	logic [12:0]  q1_q;
	logic [9:0]   q2_q;
	logic [6:0]   q3_q;
	logic [3:0]   r0_q;
	logic [3:0]   r1_q;
	logic [31:0]  p1;
	logic [28:0]  p2;
	logic [17:0]  p3;
	logic [15:0]  r0_full;
	logic [12:0]  r1_full;
	logic [9:0]   r2_full;
	queue_entry_t ent_q;

	assign accept  = req.valid && req.ready;
	assign raw_neg = req.temp_tenths[16];

	always_comb begin
		logic [16:0] neg_val;
		neg_val = 17'(-req.temp_tenths);
		if (!raw_neg) begin
			raw_mag = req.temp_tenths[15:0];
		end else if (neg_val[16]) begin
			raw_mag = 16'hFFFF;
		end else begin
			raw_mag = neg_val[15:0];
		end
	end

	assign p1      = 32'(mag_q) * 32'(16'hCCCD);
	assign p2      = 29'(q1_q) * 29'(16'hCCCD);
	assign p3      = 18'(q2_q) * 18'd205;
	assign r0_full = 16'(mag_q - 16'(q1_q) * 16'd10);
	assign r1_full = 13'(q1_q - 13'(q2_q) * 13'd10);
	assign r2_full = 10'(q2_q - 10'(q3_q) * 10'd10);

	always_comb begin
		state_d = state_q;
		case (state_q)
			FS_IDLE: begin
				if (accept) begin
					case (req.operation)
						OP_SHOW:  state_d = FS_DIV1;
						OP_WRITE: state_d = FS_PUSH;
						OP_CLEAR: state_d = FS_PUSH;
						default:  state_d = FS_IDLE;
					endcase
				end
			end
			FS_DIV1: state_d = FS_DIV2;
			FS_DIV2: state_d = FS_DIV3;
			FS_DIV3: state_d = FS_PUSH;
			FS_PUSH: begin
				if (!full) begin
					state_d = FS_IDLE;
				end
			end
			default: state_d = FS_IDLE;
		endcase
	end

	always_comb begin
		req.ready           = 1'b0;
		push                = 1'b0;
		push_entry          = ent_q;
		push_entry.d_units  = r1_q;
		push_entry.d_tens   = r2_full[3:0];
		case (state_q)
			FS_IDLE: req.ready = 1'b1;
			FS_PUSH: push = !full;
			default: begin
				req.ready = 1'b0;
				push      = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= FS_IDLE;
			prev_neg_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept && req.operation == OP_SHOW) begin
				prev_neg_q <= raw_neg;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mag_q         <= raw_mag;
			ent_q.pos     <= req.position;
			ent_q.seg     <= req.segments;
			ent_q.colon   <= req.colon;
			ent_q.use_minus <= 1'b0;
			ent_q.slot_mask <= '0;
			case (req.operation)
				OP_SHOW: begin
					ent_q.pos       <= 2'd0;
					ent_q.colon     <= 1'b0;
					ent_q.use_minus <= raw_neg;
					ent_q.slot_mask <= {3'b111, {4{!raw_neg && prev_neg_q}}, raw_neg};
				end
				OP_WRITE: ent_q.slot_mask <= 8'b0000_0001;
				OP_CLEAR: ent_q.slot_mask <= 8'b0001_1110;
				default:  ent_q.slot_mask <= '0;
			endcase
		end
		if (state_q == FS_DIV1) begin
			q1_q <= p1[31:19];
		end
		if (state_q == FS_DIV2) begin
			q2_q <= p2[28:19];
			r0_q <= r0_full[3:0];
		end
		if (state_q == FS_DIV3) begin
			q3_q <= p3[17:11];
			r1_q <= r1_full[3:0];
		end
		ent_q.d_tenths <= r0_q;
		ent_q.d_units  <= r1_q;
		ent_q.d_tens   <= 4'd0;
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == FS_PUSH && !full) |=> state_q == FS_IDLE)
		else $error("front did not return to idle after queueing");
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.operation == OP_SHOW && raw_neg) |=> prev_neg_q)
		else $error("negative flag not recorded");
	assert property (@(posedge clk) disable iff (!arst_n)
		push |-> ent_q.slot_mask != '0)
		else $error("queued plan has no digit writes");
endmodule

FILE: sv/tssfw_queue.sv
// ----------------------------------------------------------------------------
// tssfw_queue
// Short register queue of digit-write plans between front and back.
// ----------------------------------------------------------------------------
module tssfw_queue #(
	parameter int DEPTH = 2
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  tssfw_pkg::queue_entry_t push_entry,
	output logic                    full,
	input  logic                    pop,
	output tssfw_pkg::queue_entry_t pop_entry,
	output logic                    empty
);
	import tssfw_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	queue_entry_t     mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full      = count_q == CW'(DEPTH);
	assign empty     = count_q == '0;
	assign do_push   = push && !full;
	assign do_pop    = pop && !empty;
	assign pop_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue count beyond depth");
	assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count did not grow on push");
	assert property (@(posedge clk) disable iff (!arst_n)
		(do_pop && !do_push) |=> count_q == $past(count_q) - 1'b1)
		else $error("queue count did not shrink on pop");
endmodule

FILE: sv/tssfw_back.sv
// ----------------------------------------------------------------------------
// tssfw_back
// Expands queued plans into framed bus bytes, three per digit write.
// ----------------------------------------------------------------------------
module tssfw_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  tssfw_pkg::cfg_t         cfg,
	output logic                    pop,
	input  tssfw_pkg::queue_entry_t pop_entry,
	input  logic                    empty,
	tssfw_byte_if.source            rsp
);
	import tssfw_pkg::*;

	queue_entry_t          act_q;
	logic                  active_q;
	logic [2:0]            slot_q;
	logic [1:0]            phase_q;
	logic                  out_valid_q;
	logic [7:0]            out_byte_q;
	logic                  out_start_q;
	logic                  out_stop_q;
	logic                  out_last_q;
	logic                  advance;
	logic [SLOT_COUNT-1:0] higher;
	logic                  has_next;
	logic [2:0]            next_slot;
	logic [2:0]            first_slot;
	logic [1:0]            dpos;
	logic [7:0]            dseg;
	logic                  dcolon;
	logic [7:0]            seg_byte;
	logic [7:0]            cur_byte;
	logic                  cur_start;
	logic                  cur_stop;
	logic                  cur_last;

	assign pop     = !active_q && !empty;
	assign advance = active_q && (!out_valid_q || rsp.ready);

	always_comb begin
		higher     = '0;
		has_next   = 1'b0;
		next_slot  = '0;
		first_slot = '0;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			higher[i] = act_q.slot_mask[i] && (3'(i) > slot_q);
		end
		for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
			if (higher[i]) begin
				has_next  = 1'b1;
				next_slot = 3'(i);
			end
			if (pop_entry.slot_mask[i]) begin
				first_slot = 3'(i);
			end
		end
	end

	always_comb begin
		dpos   = 2'd0;
		dseg   = 8'h00;
		dcolon = 1'b0;
		case (slot_q)
			SLOT_SINGLE: begin
				dpos   = act_q.pos;
				dseg   = act_q.use_minus ? cfg.minus_pat : act_q.seg;
				dcolon = act_q.colon;
			end
			SLOT_CLR3:   dpos = 2'd3;
			SLOT_CLR2:   dpos = 2'd2;
			SLOT_CLR1:   dpos = 2'd1;
			SLOT_CLR0:   dpos = 2'd0;
			SLOT_TENTHS: begin
				dpos = 2'd3;
				dseg = digit_pattern(act_q.d_tenths);
			end
			SLOT_UNITS: begin
				dpos   = 2'd2;
				dseg   = digit_pattern(act_q.d_units);
				dcolon = 1'b1;
			end
			SLOT_TENS: begin
				dpos = 2'd1;
				dseg = digit_pattern(act_q.d_tens);
			end
			default: dpos = 2'd0;
		endcase
		seg_byte = dcolon ? (dseg | COLON_BIT) : (dseg & ~COLON_BIT);
	end

	always_comb begin
		cur_byte  = cfg.data_cmd;
		cur_start = 1'b1;
		cur_stop  = 1'b1;
		cur_last  = 1'b0;
		case (phase_q)
			PH_DATA: begin
				cur_byte  = cfg.data_cmd;
				cur_start = 1'b1;
				cur_stop  = 1'b1;
			end
			PH_ADDR: begin
				cur_byte  = cfg.addr_cmd | {6'd0, dpos};
				cur_start = 1'b1;
				cur_stop  = 1'b0;
			end
			PH_SEG: begin
				cur_byte  = seg_byte;
				cur_start = 1'b0;
				cur_stop  = 1'b1;
				cur_last  = !has_next;
			end
			default: cur_byte = cfg.data_cmd;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			out_valid_q <= 1'b0;
			slot_q      <= '0;
			phase_q     <= PH_DATA;
		end else begin
			if (pop) begin
				active_q <= 1'b1;
				slot_q   <= first_slot;
				phase_q  <= PH_DATA;
			end else if (advance) begin
				if (phase_q == PH_SEG) begin
					phase_q <= PH_DATA;
					slot_q  <= next_slot;
					if (!has_next) begin
						active_q <= 1'b0;
					end
				end else begin
					phase_q <= phase_q + 1'b1;
				end
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			act_q <= pop_entry;
		end
		if (advance) begin
			out_byte_q  <= cur_byte;
			out_start_q <= cur_start;
			out_stop_q  <= cur_stop;
			out_last_q  <= cur_last;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.bus_byte     = out_byte_q;
	assign rsp.start_before = out_start_q;
	assign rsp.stop_after   = out_stop_q;
	assign rsp.last         = out_last_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> act_q.slot_mask[slot_q])
		else $error("sequencer sits on a disabled slot");
	assert property (@(posedge clk) disable iff (!arst_n)
		(advance && cur_last) |=> !active_q)
		else $error("sequencer still busy after final byte");
	assert property (@(posedge clk) disable iff (!arst_n)
		(advance && cur_last) |-> phase_q == PH_SEG)
		else $error("final byte is not a segment byte");
endmodule

FILE: sv/temperature_seven_segment_frame_writer_unit.sv
// ----------------------------------------------------------------------------
// temperature_seven_segment_frame_writer_unit
// Turns display requests into framed bytes for a two-wire segment display.
// ----------------------------------------------------------------------------
// Requests enter on req (show temperature, write one position, clear) and
// leave as bus bytes on rsp, each with its start and stop marks; the final
// byte of a request carries last. Each digit write makes three bytes.
// A request makes 3 to 21 bytes; operation code 3 makes none.
// The cfg channel writes the data command, the address base and the minus
// pattern; it is always ready and should be used only while idle.
// The front takes a show request and runs the decimal split (three
// reciprocal multiplies, one per cycle, in states DIV1 to DIV3) before
// queueing it; other requests go straight to the push state. The back
// sends one byte per cycle while rsp is ready, and the first byte of a
// show request passes the split states, the queue and the output register.
// The front accepts the next item while the back is still sending.
// When rsp stalls, the output register holds its byte and the queue fills,
// after which req.ready drops. Reset empties the queue, clears the sign
// history and loads the register defaults.
// ----------------------------------------------------------------------------
module temperature_seven_segment_frame_writer_unit #(
	parameter int QUEUE_DEPTH = 2
) (
	input logic          clk,
	input logic          arst_n,
	tssfw_req_if.sink    req,
	tssfw_byte_if.source rsp,
	tssfw_cfg_if.sink    cfg
);
	import tssfw_pkg::*;

	cfg_t         cfg_q;
	logic         push;
	logic         pop;
	logic         full;
	logic         empty;
	queue_entry_t push_entry;
	queue_entry_t pop_entry;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.data_cmd  <= 8'd68;
			cfg_q.addr_cmd  <= 8'd192;
			cfg_q.minus_pat <= 8'd64;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_DATA_CMD:  cfg_q.data_cmd  <= cfg.data;
				CFG_ADDR_CMD:  cfg_q.addr_cmd  <= cfg.data;
				CFG_MINUS_PAT: cfg_q.minus_pat <= cfg.data;
				default:       cfg_q <= cfg_q;
			endcase
		end
	end

	tssfw_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.push       (push),
		.push_entry (push_entry),
		.full       (full)
	);

	tssfw_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (full),
		.pop        (pop),
		.pop_entry  (pop_entry),
		.empty      (empty)
	);

	tssfw_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pop       (pop),
		.pop_entry (pop_entry),
		.empty     (empty),
		.rsp       (rsp)
	);
endmodule
